// File: rtl/sld_pkg.sv
// Package: shared types, year-code table and day-number helper for the lunar date converter.
package sld_pkg;

    localparam int TABLE_LEN = 100;
    localparam int JD_W      = 22;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JD,
        ST_YEAR,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;   // capture input word, begin day number
        logic load_yr; // load year code of the current candidate year
        logic step;    // advance one month in the scan
        logic retry;   // move to previous/next lunar year
    } t_cmd;

    typedef struct packed {
        logic covered;  // candidate year in table
        logic early;    // jd precedes candidate year start
        logic after;    // jd beyond candidate year end (checked once)
        logic hit;      // jd inside current month
        logic last;     // current month is the last of the year
        logic tried;    // year already adjusted once
    } t_sts;

    typedef struct packed {
        logic [4:0]      lunar_day;
        logic [3:0]      lunar_month;
        logic [11:0]     lunar_year;
        logic            is_leap_month;
        logic [JD_W-1:0] julian_day;
        logic            in_range;
    } t_res;

    typedef struct packed {
        logic [4:0]  solar_day;
        logic [3:0]  solar_month;
        logic [11:0] solar_year;
    } t_date;

    localparam logic [23:0] YEAR_CODE [TABLE_LEN] = '{
        24'h46c960, 24'h2ed954, 24'h54d4a0, 24'h3eda50, 24'h2a7552, 24'h4e56a0, 24'h38a7a7,
        24'h5ea5d0, 24'h4a92b0, 24'h32aab5, 24'h58a950, 24'h42b4a0, 24'h2cbaa4, 24'h50ad50,
        24'h3c55d9, 24'h624ba0, 24'h4ca5b0, 24'h375176, 24'h5c5270, 24'h466930, 24'h307934,
        24'h546aa0, 24'h3ead50, 24'h2a5b52, 24'h504b60, 24'h38a6e6, 24'h5ea4e0, 24'h48d260,
        24'h32ea65, 24'h56d520, 24'h40daa0, 24'h2d56a3, 24'h5256d0, 24'h3c4afb, 24'h6249d0,
        24'h4ca4d0, 24'h37d0b6, 24'h5ab250, 24'h44b520, 24'h2edd25, 24'h54b5a0, 24'h3e55d0,
        24'h2a55b2, 24'h5049b0, 24'h3aa577, 24'h5ea4b0, 24'h48aa50, 24'h33b255, 24'h586d20,
        24'h40ad60, 24'h2d4b63, 24'h525370, 24'h3e49e8, 24'h60c970, 24'h4c54b0, 24'h3768a6,
        24'h5ada50, 24'h445aa0, 24'h2fa6a4, 24'h54aad0, 24'h4052e0, 24'h28d2e3, 24'h4ec950,
        24'h38d557, 24'h5ed4a0, 24'h46d950, 24'h325d55, 24'h5856a0, 24'h42a6d0, 24'h2c55d4,
        24'h5252b0, 24'h3ca9b8, 24'h62a930, 24'h4ab490, 24'h34b6a6, 24'h5aad50, 24'h4655a0,
        24'h2eab64, 24'h54a570, 24'h4052b0, 24'h2ab173, 24'h4e6930, 24'h386b37, 24'h5e6aa0,
        24'h48ad50, 24'h332ad5, 24'h582b60, 24'h42a570, 24'h2e52e4, 24'h50d160, 24'h3ae958,
        24'h60d520, 24'h4ada90, 24'h355aa6, 24'h5a56d0, 24'h462ae0, 24'h30a9d4, 24'h54a2d0,
        24'h3ed150, 24'h28e952
    };

    // x / 100 by reciprocal multiply; exact for x below 16384.
    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [27:0] p;
        begin
            p      = 28'(x) * 28'd10486;
            div100 = p[27:20];
        end
    endfunction

    // (153 * mm + 2) / 5 for the shifted month mm = 0..11 (12 for month 15).
    function automatic logic [8:0] month_offset(input logic [4:0] mm);
        begin
            case (mm)
                5'd1:    month_offset = 9'd31;
                5'd2:    month_offset = 9'd61;
                5'd3:    month_offset = 9'd92;
                5'd4:    month_offset = 9'd122;
                5'd5:    month_offset = 9'd153;
                5'd6:    month_offset = 9'd184;
                5'd7:    month_offset = 9'd214;
                5'd8:    month_offset = 9'd245;
                5'd9:    month_offset = 9'd275;
                5'd10:   month_offset = 9'd306;
                5'd11:   month_offset = 9'd337;
                5'd12:   month_offset = 9'd367;
                default: month_offset = 9'd0;
            endcase
        end
    endfunction

    // Day number of 1 January of year y (y <= 4095), constant divisors only.
    function automatic logic [JD_W-1:0] jan1_jd(input logic [11:0] y);
        logic [13:0] yy;
        logic [7:0]  q;
        logic [23:0] s;
        begin
            yy = 14'(y) + 14'd4799;
            q  = div100(yy);
            s  = 24'd306 + 24'(yy) * 24'd365 + 24'(yy[13:2]) - 24'(q)
                 + 24'(q[7:2]) - 24'd32045 + 24'd1;
            jan1_jd = s[JD_W-1:0];
        end
    endfunction

endpackage

// File: rtl/sld_if.sv
// Interfaces: valid/ready channels for the input date word and the result word.
interface sld_in_if;
    logic              valid;
    logic              ready;
    sld_pkg::t_date    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sld_out_if;
    logic              valid;
    logic              ready;
    sld_pkg::t_res     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/solar_to_lunar_date.sv
// Top level: Gregorian to lunar date converter, controller plus datapath.
// One date word in, one result word out. Each word has its day number captured
// and its year code loaded; a month sequencer then steps through the year's
// lunar months (up to 13). A date in the previous or next lunar year moves the
// candidate year and reloads its code, once. The result is held until taken,
// and the next word is only taken once the result has gone. A word outside the
// table gives in_range 0 with zero lunar fields; julian_day is always given.
module solar_to_lunar_date #(
    parameter int FIRST_YEAR = 2000,
    parameter int YEAR_COUNT = 100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sld_in_if.sink    i_date,
    sld_out_if.source o_lunar
);
    import sld_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic done_ok, finish;

    sld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_date.valid),
        .o_in_ready (i_date.ready),
        .o_out_valid(o_lunar.valid),
        .i_out_ready(o_lunar.ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_done_ok  (done_ok),
        .o_finish   (finish)
    );

    sld_dp #(.FIRST_YEAR(FIRST_YEAR), .YEAR_COUNT(YEAR_COUNT)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_date   (i_date.data),
        .i_cmd    (cmd),
        .i_done_ok(done_ok),
        .i_finish (finish),
        .o_sts    (sts),
        .o_res    (o_lunar.data)
    );
endmodule

// File: rtl/sld_ctrl.sv
// Controller: sequences day number, year select and month scan.
module sld_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sld_pkg::t_sts i_sts,
    output sld_pkg::t_cmd o_cmd,
    output logic          o_done_ok,
    output logic          o_finish
);
    import sld_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_JD;
            ST_JD:   n_state = ST_YEAR;
            ST_YEAR: begin
                if (!i_sts.covered) n_state = ST_DONE;
                else if ((i_sts.early || i_sts.after) && !i_sts.tried) n_state = ST_JD;
                else if (i_sts.early) n_state = ST_DONE;
                else n_state = ST_SCAN;
            end
            ST_SCAN: if (i_sts.hit || i_sts.last) n_state = ST_DONE;
            ST_DONE: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_done_ok   = 1'b0;
        o_finish    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_JD:   o_cmd.load_yr = 1'b1;
            ST_YEAR: begin
                o_cmd.retry = i_sts.covered && (i_sts.early || i_sts.after) && !i_sts.tried;
                o_finish    = !i_sts.covered || (i_sts.early && i_sts.tried);
            end
            ST_SCAN: begin
                o_cmd.step = !i_sts.hit;
                o_done_ok  = i_sts.hit;
                o_finish   = i_sts.hit || i_sts.last;
            end
            ST_DONE: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("accept while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_out_ready) |=> r_state == ST_DONE)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == ST_JD) else $error("start lost");
endmodule

// File: rtl/sld_dp.sv
// Datapath: day number, year code fetch, month start accumulation and result register.
module sld_dp #(
    parameter int FIRST_YEAR = 2000,
    parameter int YEAR_COUNT = 100
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sld_pkg::t_date i_date,
    input  sld_pkg::t_cmd  i_cmd,
    input  logic           i_done_ok,
    input  logic           i_finish,
    output sld_pkg::t_sts  o_sts,
    output sld_pkg::t_res  o_res
);
    import sld_pkg::*;

    localparam int CNT = (YEAR_COUNT < TABLE_LEN) ? YEAR_COUNT : TABLE_LEN;

    logic [JD_W-1:0] r_jd, r_start;
    logic [11:0]     r_ly;
    logic [23:0]     r_code;
    logic            r_cov, r_tried, r_leapph;
    logic [3:0]      r_mon;
    logic [JD_W-1:0] r_jan1;
    t_res            r_res;

    // Arithmetic day number of the input date.
    logic [13:0]     yy;
    logic [4:0]      mm;
    logic            a;
    logic [7:0]      q100;
    logic [23:0]     jd_s;
    always_comb begin
        a    = (i_date.solar_month <= 4'd2);
        yy   = 14'(i_date.solar_year) + 14'd4800 - 14'(a);
        mm   = 5'(i_date.solar_month) + (a ? 5'd12 : 5'd0) - 5'd3;
        q100 = div100(yy);
        jd_s = 24'(month_offset(mm)) + 24'(yy) * 24'd365 + 24'(yy[13:2])
               - 24'(q100) + 24'(q100[7:2]) - 24'd32045 + 24'(i_date.solar_day);
    end

    logic [12:0] idx_w;
    logic        cov;
    assign idx_w = 13'(r_ly) - 13'(FIRST_YEAR);
    assign cov   = ($signed(14'(r_ly)) - $signed(14'(FIRST_YEAR)) >= 0) && (idx_w < 13'(CNT));

    logic [3:0]  leap_no;
    logic        cur_bit;
    logic [4:0]  cur_len;
    logic [JD_W-1:0] yr_start;
    assign leap_no  = (r_code[3:0] > 4'd12) ? 4'd0 : r_code[3:0];
    assign cur_bit  = r_leapph ? r_code[16] : r_code[5'd16 - 5'(r_mon)];
    assign cur_len  = cur_bit ? 5'd30 : 5'd29;
    assign yr_start = r_jan1 + JD_W'(r_code[23:17]);

    // Year length: twelve months of 29 plus ones, plus leap month.
    logic [8:0] ylen;
    always_comb begin
        ylen = 9'd348 + 9'($countones(r_code[15:4]));
        if (leap_no != 4'd0) ylen = ylen + 9'd29 + 9'(r_code[16]);
    end

    // Candidate year bounds, valid in ST_YEAR straight after the code load.
    logic [JD_W-1:0] yr_end;
    logic            early;
    assign yr_end = yr_start + JD_W'(ylen);
    assign early  = r_jd < yr_start;

    assign o_sts.covered = r_cov;
    assign o_sts.early   = early;
    assign o_sts.after   = r_jd >= yr_end;
    assign o_sts.hit     = (r_jd >= r_start) && (r_jd < r_start + JD_W'(cur_len));
    assign o_sts.last    = (r_mon == 4'd12) && (r_leapph || leap_no != 4'd12);
    assign o_sts.tried   = r_tried;
    assign o_res         = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_jd    <= jd_s[JD_W-1:0];
            r_ly    <= i_date.solar_year;
            r_tried <= 1'b0;
        end
        if (i_cmd.retry) begin
            r_ly    <= early ? r_ly - 12'd1 : r_ly + 12'd1;
            r_tried <= 1'b1;
        end
        if (i_cmd.load_yr) begin
            r_cov    <= cov;
            r_code   <= cov ? YEAR_CODE[idx_w[6:0]] : 24'd0;
            r_jan1   <= jan1_jd(r_ly);
            r_mon    <= 4'd1;
            r_leapph <= 1'b0;
        end
        // follows the year start until the scan, then walks month by month
        r_start <= i_cmd.step ? r_start + JD_W'(cur_len) : yr_start;
        if (i_cmd.step) begin
            if (!r_leapph && r_mon == leap_no) begin
                r_leapph <= 1'b1;
            end else begin
                r_leapph <= 1'b0;
                r_mon    <= r_mon + 4'd1;
            end
        end
        if (i_finish) begin
            r_res.julian_day    <= r_jd;
            r_res.in_range      <= i_done_ok;
            r_res.lunar_day     <= i_done_ok ? 5'(r_jd - r_start + JD_W'(1)) : 5'd0;
            r_res.lunar_month   <= i_done_ok ? r_mon : 4'd0;
            r_res.lunar_year    <= i_done_ok ? r_ly : 12'd0;
            r_res.is_leap_month <= i_done_ok && r_leapph;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !i_done_ok) else $error("step on hit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.retry |=> r_tried) else $error("retry not marked");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done_ok |-> o_sts.hit) else $error("done without hit");
endmodule

// File: tb/tb_top.sv
// Testbench for the Gregorian to lunar date converter: directed table, random dates, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    localparam int FIRST_YR  = 2000;
    localparam int YR_COUNT  = 100;
    localparam int N_RANDOM  = 1130;
    localparam int N_DIRECT  = 24;

    logic i_clk;
    logic i_rst_n;

    sld_in_if  date_ch ();
    sld_out_if lunar_ch ();

    solar_to_lunar_date #(
        .FIRST_YEAR (FIRST_YR),
        .YEAR_COUNT (YR_COUNT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (date_ch),
        .o_lunar (lunar_ch)
    );

    // Results still owed by the block, oldest first.
    t_res lunar_due[$];

    int n_mismatch;
    int n_words_out;
    int n_valid_out;
    int n_leap_out;
    bit quiet_phase;  // set while both sides run without idling

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling for ~1150 words, with stalls.
    initial begin
        #5ms;
        $display("** solar_to_lunar_date: FAILED **");
        $finish;
    end

    // Day number with arithmetic month extension (months 0 and 13..15 allowed).
    function automatic longint jdn(input int d, input int m, input int y);
        int     a;
        longint yy;
        longint mm;
        begin
            a  = (m <= 2) ? 1 : 0;
            yy = y + 4800 - a;
            mm = m + 12 * a - 3;
            jdn = (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045 + d;
        end
    endfunction

    function automatic bit yr_in_table(input longint y);
        return (y >= FIRST_YR) && (y < FIRST_YR + YR_COUNT) && (y - FIRST_YR < TABLE_LEN);
    endfunction

    function automatic longint new_year_jd(input longint y);
        return jdn(1, 1, int'(y)) + longint'(YEAR_CODE[y - FIRST_YR] >> 17);
    endfunction

    function automatic int month_len(input logic [23:0] code, input int m, input bit leap);
        if (leap)
            return code[16] ? 30 : 29;
        return code[16 - m] ? 30 : 29;
    endfunction

    function automatic int year_len(input longint y);
        logic [23:0] code;
        int          total;
        int          lm;
        begin
            code  = YEAR_CODE[y - FIRST_YR];
            lm    = (code[3:0] > 12) ? 0 : code[3:0];
            total = 0;
            for (int m = 1; m <= 12; m++) begin
                total += month_len(code, m, 1'b0);
                if (m == lm)
                    total += month_len(code, m, 1'b1);
            end
            return total;
        end
    endfunction

    // Expected lunar date for one input word.
    function automatic t_res lunar_of(input t_date w);
        t_res        r;
        longint      jd;
        longint      ly;
        longint      st;
        logic [23:0] code;
        int          lm;
        int          len;
        begin
            r  = '0;
            jd = jdn(w.solar_day, w.solar_month, w.solar_year);
            r.julian_day = jd[JD_W-1:0];
            if (!yr_in_table(w.solar_year))
                return r;
            ly = w.solar_year;
            st = new_year_jd(ly);
            if (jd < st)
                ly = ly - 1;
            else if (jd >= st + year_len(ly))
                ly = ly + 1;
            if (!yr_in_table(ly))
                return r;
            code = YEAR_CODE[ly - FIRST_YR];
            lm   = (code[3:0] > 12) ? 0 : code[3:0];
            st   = new_year_jd(ly);
            for (int m = 1; m <= 12; m++) begin
                for (int k = 0; k < 2; k++) begin
                    if (k == 1 && m != lm)
                        continue;
                    len = month_len(code, m, k == 1);
                    if (jd >= st && jd < st + len) begin
                        r.lunar_day     = 5'(jd - st + 1);
                        r.lunar_month   = 4'(m);
                        r.lunar_year    = 12'(ly);
                        r.is_leap_month = (k == 1);
                        r.in_range      = 1'b1;
                        return r;
                    end
                    st += len;
                end
            end
            return r;
        end
    endfunction

    // Directed rows: date plus, where obvious, the result typed in.
    typedef struct {
        t_date w;
        bit    typed;
        t_res  r;
    } t_row;

    t_row directed[N_DIRECT];

    function automatic t_row row(input int d, input int m, input int y);
        t_row x;
        x.w     = '{solar_day: 5'(d), solar_month: 4'(m), solar_year: 12'(y)};
        x.typed = 1'b0;
        x.r     = '0;
        return x;
    endfunction

    function automatic t_row row_out(input int d, input int m, input int y, input int jd);
        t_row x;
        x = row(d, m, y);
        x.typed        = 1'b1;
        x.r.julian_day = JD_W'(jd);
        return x;
    endfunction

    initial begin
        directed[0]  = row_out(1, 1, 2000, 2451545);      // before the first new year
        directed[1]  = row_out(1, 1, 1999, 2451180);      // year below the table
        directed[2]  = row_out(1, 1, 2100, 2488070);      // year above the table
        directed[3]  = row(5, 2, 2000);                   // first new year day
        directed[4]  = row(31, 12, 2099);
        directed[5]  = row(0, 0, 2000);                   // day 0, month 0
        directed[6]  = row(31, 15, 2099);                 // month past December
        directed[7]  = row(31, 13, 2098);
        directed[8]  = row(0, 1, 2050);
        directed[9]  = row(31, 2, 2024);                  // day beyond month end
        directed[10] = row(1, 1, 2001);                   // falls in previous lunar year
        directed[11] = row(15, 5, 2001);                  // 2001 has leap month 4; this date is before it
        directed[12] = row(20, 7, 2006);                  // 2006 has leap month 7; this date is before it
        directed[13] = row(25, 10, 2033);                 // 2033 has leap month 11; this date is before it
        directed[14] = row(1, 3, 2020);
        directed[15] = row(29, 2, 2000);
        directed[16] = row(31, 12, 2000);
        directed[17] = row(31, 15, 4095);                 // all ones
        directed[18] = row(0, 0, 0);                      // all zeros
        directed[19] = row(16, 8, 2047);
        directed[20] = row(21, 4, 2063);
        directed[21] = row(10, 6, 2090);
        directed[22] = row(1, 14, 2099);                  // spills into 2100
        directed[23] = row(31, 0, 2000);                  // December 1999
    end

    // Hold-off: each call idles with chance 21 in a hundred, never in the quiet stretch.
    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 21);
    endfunction

    // Leaves valid as it stood at the accepting edge; the caller drops it at the end.
    task automatic send(input t_date w);
        date_ch.valid <= !idle_now();
        date_ch.data  <= w;
        @(posedge i_clk);
        while (!(date_ch.valid && date_ch.ready)) begin
            date_ch.valid <= !idle_now();
            @(posedge i_clk);
        end
    endtask

    function automatic t_date rand_date();
        t_date w;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 85) begin
            w.solar_year  = 12'($urandom_range(FIRST_YR + YR_COUNT - 1, FIRST_YR));
            w.solar_month = 4'($urandom_range(12, 1));
            w.solar_day   = 5'($urandom_range(28, 1));
            if ($urandom_range(3) == 0)
                w.solar_day = 5'($urandom_range(31, 29));
        end else begin
            // odd fields: any bit pattern, or a year just around the table
            w.solar_year  = ($urandom_range(1) == 0) ? 12'($urandom) : 12'($urandom_range(2101, 1998));
            w.solar_month = 4'($urandom);
            w.solar_day   = 5'($urandom);
        end
        return w;
    endfunction

    // Check each result word against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && lunar_ch.valid && lunar_ch.ready) begin
            n_words_out++;
            if (lunar_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] unexpected result word %p", $realtime, lunar_ch.data);
            end else begin
                t_res e;
                e = lunar_due.pop_front();
                if (e.in_range)      n_valid_out++;
                if (e.is_leap_month) n_leap_out++;
                if (lunar_ch.data !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("[%0t] mismatch: exp %p got %p", $realtime, e, lunar_ch.data);
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            lunar_ch.ready <= 1'b0;
        else
            lunar_ch.ready <= !idle_now();
    end

    initial begin
        t_date w;
        int    wait_cnt;
        i_rst_n       = 1'b0;
        date_ch.valid = 1'b0;
        date_ch.data  = '0;
        quiet_phase   = 1'b0;
        n_mismatch    = 0;
        n_words_out   = 0;
        n_valid_out   = 0;
        n_leap_out    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed-in rows cross-check the predictor too
        for (int i = 0; i < N_DIRECT; i++) begin
            if (directed[i].typed && lunar_of(directed[i].w) !== directed[i].r) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("table row %0d: exp %p predictor %p", i, directed[i].r,
                             lunar_of(directed[i].w));
            end
            lunar_due.push_back(directed[i].typed ? directed[i].r : lunar_of(directed[i].w));
            send(directed[i].w);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            quiet_phase = (i >= 400 && i < 600);
            w = rand_date();
            lunar_due.push_back(lunar_of(w));
            send(w);
        end
        date_ch.valid <= 1'b0;
        quiet_phase = 1'b0;

        wait_cnt = 0;
        while (lunar_due.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (40) @(posedge i_clk);

        $display("Converted %0d dates: %0d in table range, %0d in leap months.",
                 n_words_out, n_valid_out, n_leap_out);
        $display("Mismatches: %0d, words still owed: %0d.", n_mismatch, lunar_due.size());
        if (n_mismatch == 0 && lunar_due.size() == 0)
            $display("** solar_to_lunar_date: PASSED **");
        else
            $display("** solar_to_lunar_date: FAILED **");
        $finish;
    end

endmodule
